### rtl/toe_pkg.sv
// ----------------------------------------------------------------------------
// Topological order engine package
// Shared types, codes and default sizes for the topological order engine.
// ----------------------------------------------------------------------------
package toe_pkg;

  localparam int unsigned VTX_W = 13;
  localparam int unsigned DEFAULT_MAX_VERTICES = 4096;
  localparam int unsigned DEFAULT_MAX_EDGES = 16384;
  localparam logic [VTX_W-1:0] VCOUNT_RESET = 13'd1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PULL  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [VTX_W-1:0] edge_source;
    logic [VTX_W-1:0] edge_target;
  } item_t;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             vertex_valid;
    logic             done_res;
    status_t          status;
  } result_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD_CHK,
    S_LOAD_WR,
    S_SEED,
    S_POP_RD,
    S_POP_WAIT,
    S_HEAD,
    S_EDGE_RD,
    S_DEG_RD,
    S_DEG_WR,
    S_FINISH
  } state_t;

endpackage

### rtl/toe_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module toe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/topological_order_engine.sv
// ----------------------------------------------------------------------------
// Topological order engine
// Kahn topological sort over a directed graph held in on-chip RAMs.
// ----------------------------------------------------------------------------
// The engine takes one transaction at a time and returns exactly one result
// transaction for each. A load is checked, then written unless it fails the
// check. In a pull, every edge of the popped vertex costs one read of the edge
// RAMs, one read of the degree RAM and one write back, and that degree
// read-modify-write loop sets the pull rate. A pull on an empty queue goes
// from the pop state straight to its result. The first pull after reset or
// clear first sweeps the degree RAM over the vertices in use. After reset, and
// after every clear transaction, a clearing pass over all MAX_VERTICES entries
// zeroes the degree and adjacency RAMs; item_ready is low meanwhile, while
// configuration writes are always taken.
module topological_order_engine
  import toe_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = DEFAULT_MAX_VERTICES,
  parameter int unsigned MAX_EDGES    = DEFAULT_MAX_EDGES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [VTX_W-1:0] cfg_data,
  input  logic             item_valid,
  output logic             item_ready,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_ready,
  output result_t          result
);

  // Address widths of the vertex-indexed and edge-indexed RAMs.
  localparam int unsigned VAW = $clog2(MAX_VERTICES);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  // Edge links are stored as edge index plus one, zero meaning empty.
  localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned DW  = EW;
  localparam int unsigned LW  = $clog2(MAX_VERTICES + 1);
  // Largest vertex number the 13-bit fields can reach under this capacity.
  localparam int unsigned VCAP = (MAX_VERTICES < 8191) ? MAX_VERTICES : 8191;
  localparam logic [VTX_W-1:0] VCAP_V = VTX_W'(VCAP);
  localparam logic [VAW-1:0]   VLAST  = VAW'(MAX_VERTICES - 1);
  localparam logic [EW-1:0]    ECAP   = EW'(MAX_EDGES);

  state_t state, state_next;

  logic [VTX_W-1:0] vcount;
  logic [VTX_W-1:0] n_eff;
  item_t            item_q;
  result_t          res;
  logic [EW-1:0]    edge_count;
  logic             seeded;
  logic [VAW-1:0]   clr_cnt;
  logic             clr_reply;
  logic [VTX_W-1:0] seed_idx;
  logic             seed_pend;
  logic [VAW-1:0]   seed_addr;
  logic [VAW-1:0]   fifo_rd;
  logic [VAW-1:0]   fifo_wr;
  logic [LW-1:0]    fifo_len;
  logic [EW-1:0]    link;
  logic [EW-1:0]    tail_link;
  logic [EW-1:0]    next_link;
  logic [VAW-1:0]   w_idx;

  // RAM ports.
  logic             deg_we;
  logic [VAW-1:0]   deg_waddr, deg_raddr;
  logic [DW:0]      deg_wdata, deg_rdata;
  logic             adj_we;
  logic [VAW-1:0]   adj_waddr, adj_raddr;
  logic [2*EW-1:0]  adj_wdata, adj_rdata;
  logic             tgt_we;
  logic [EAW-1:0]   tgt_waddr, tgt_raddr;
  logic [VAW-1:0]   tgt_wdata, tgt_rdata;
  logic             nxt_we;
  logic [EAW-1:0]   nxt_waddr, nxt_raddr;
  logic [EW-1:0]    nxt_wdata, nxt_rdata;
  logic             fifo_we;
  logic [VAW-1:0]   fifo_wdata, fifo_rdata;

  // Decoded conditions.
  logic             load_bad;
  logic             load_full;
  logic [VAW-1:0]   src_idx, tgt_idx;
  logic [EW-1:0]    adj_head, adj_tail;
  logic [EW-1:0]    edge_inc;
  logic             seed_hit;
  logic             seed_end;
  logic [DW-1:0]    deg_dec;
  logic             walk_push;
  logic             walk_last;
  logic             out_free;

  assign cfg_ready  = 1'b1;
  assign n_eff      = (vcount > VCAP_V) ? VCAP_V : vcount;
  assign load_bad   = (item_q.edge_source == '0) || (item_q.edge_source > n_eff) ||
                      (item_q.edge_target == '0) || (item_q.edge_target > n_eff);
  assign load_full  = (edge_count == ECAP);
  assign src_idx    = VAW'(item_q.edge_source - VTX_W'(1));
  assign tgt_idx    = VAW'(item_q.edge_target - VTX_W'(1));
  assign adj_head   = adj_rdata[2*EW-1:EW];
  assign adj_tail   = adj_rdata[EW-1:0];
  assign edge_inc   = edge_count + EW'(1);
  // A seeding candidate has no incoming edges left and was never queued.
  assign seed_hit   = seed_pend && (deg_rdata[DW-1:0] == '0) && !deg_rdata[DW];
  assign seed_end   = (seed_idx >= n_eff) && !seed_pend;
  // A degree already at zero stays there.
  assign deg_dec    = (deg_rdata[DW-1:0] == '0) ? '0 : deg_rdata[DW-1:0] - DW'(1);
  assign walk_push  = !deg_rdata[DW] && (deg_dec == '0);
  assign walk_last  = (link == tail_link);
  assign out_free   = !result_valid || result_ready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == VLAST) begin
          state_next = clr_reply ? S_FINISH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          case (item.op)
            OP_LOAD:  state_next = S_LOAD_CHK;
            OP_PULL:  state_next = seeded ? S_POP_RD : S_SEED;
            OP_CLEAR: state_next = S_CLEAR;
            default:  state_next = S_FINISH;
          endcase
        end
      end
      S_LOAD_CHK: state_next = (load_bad || load_full) ? S_FINISH : S_LOAD_WR;
      S_LOAD_WR:  state_next = S_FINISH;
      S_SEED:     state_next = seed_end ? S_POP_RD : S_SEED;
      S_POP_RD:   state_next = (fifo_len == '0) ? S_FINISH : S_POP_WAIT;
      S_POP_WAIT: state_next = S_HEAD;
      S_HEAD:     state_next = (adj_head == '0) ? S_FINISH : S_EDGE_RD;
      S_EDGE_RD:  state_next = S_DEG_RD;
      S_DEG_RD:   state_next = S_DEG_WR;
      S_DEG_WR:   state_next = walk_last ? S_FINISH : S_EDGE_RD;
      S_FINISH:   state_next = out_free ? S_IDLE : S_FINISH;
      default:    state_next = S_IDLE;
    endcase
  end

  // RAM control and handshake outputs.
  always_comb begin
    item_ready = 1'b0;
    deg_we     = 1'b0;
    deg_waddr  = '0;
    deg_wdata  = '0;
    deg_raddr  = '0;
    adj_we     = 1'b0;
    adj_waddr  = '0;
    adj_wdata  = '0;
    adj_raddr  = '0;
    tgt_we     = 1'b0;
    tgt_waddr  = EAW'(edge_count);
    tgt_wdata  = tgt_idx;
    tgt_raddr  = EAW'(link - EW'(1));
    nxt_we     = 1'b0;
    nxt_waddr  = EAW'(adj_tail - EW'(1));
    nxt_wdata  = edge_inc;
    nxt_raddr  = EAW'(link - EW'(1));
    fifo_we    = 1'b0;
    fifo_wdata = seed_addr;
    unique case (state)
      S_CLEAR: begin
        deg_we    = 1'b1;
        deg_waddr = clr_cnt;
        adj_we    = 1'b1;
        adj_waddr = clr_cnt;
      end
      S_IDLE: begin
        item_ready = 1'b1;
      end
      S_LOAD_CHK: begin
        adj_raddr = src_idx;
        deg_raddr = tgt_idx;
      end
      S_LOAD_WR: begin
        // Append the new edge at the tail of the source's list.
        adj_we    = 1'b1;
        adj_waddr = src_idx;
        adj_wdata = {((adj_tail == '0) ? edge_inc : adj_head), edge_inc};
        nxt_we    = (adj_tail != '0);
        tgt_we    = 1'b1;
        deg_we    = 1'b1;
        deg_waddr = tgt_idx;
        deg_wdata = {deg_rdata[DW], deg_rdata[DW-1:0] + DW'(1)};
      end
      S_SEED: begin
        // Read one vertex ahead while the previous one is checked and marked.
        deg_raddr = VAW'(seed_idx);
        if (seed_hit) begin
          deg_we     = 1'b1;
          deg_waddr  = seed_addr;
          deg_wdata  = {1'b1, deg_rdata[DW-1:0]};
          fifo_we    = 1'b1;
          fifo_wdata = seed_addr;
        end
      end
      S_POP_WAIT: begin
        adj_raddr = fifo_rdata;
      end
      S_DEG_RD: begin
        deg_raddr = tgt_rdata;
      end
      S_DEG_WR: begin
        deg_we     = 1'b1;
        deg_waddr  = w_idx;
        deg_wdata  = {deg_rdata[DW] | walk_push, deg_dec};
        fifo_we    = walk_push;
        fifo_wdata = w_idx;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      vcount       <= VCOUNT_RESET;
      edge_count   <= '0;
      seeded       <= 1'b0;
      clr_cnt      <= '0;
      clr_reply    <= 1'b0;
      seed_idx     <= '0;
      seed_pend    <= 1'b0;
      fifo_rd      <= '0;
      fifo_wr      <= '0;
      fifo_len     <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        vcount <= cfg_data;
      end
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (fifo_we) begin
        fifo_wr <= (fifo_wr == VLAST) ? '0 : fifo_wr + VAW'(1);
      end
      if (fifo_we && !(state == S_POP_RD && fifo_len != '0)) begin
        fifo_len <= fifo_len + LW'(1);
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= (clr_cnt == VLAST) ? '0 : clr_cnt + VAW'(1);
        end
        S_IDLE: begin
          seed_idx  <= '0;
          seed_pend <= 1'b0;
          if (item_valid && item.op == OP_CLEAR) begin
            edge_count <= '0;
            seeded     <= 1'b0;
            fifo_rd    <= '0;
            fifo_wr    <= '0;
            fifo_len   <= '0;
            clr_reply  <= 1'b1;
          end
        end
        S_LOAD_CHK: begin
        end
        S_LOAD_WR: begin
          edge_count <= edge_inc;
        end
        S_SEED: begin
          seed_pend <= (seed_idx < n_eff);
          if (seed_idx < n_eff) begin
            seed_idx <= seed_idx + VTX_W'(1);
          end
          if (seed_end) begin
            seeded <= 1'b1;
          end
        end
        S_POP_RD: begin
          if (fifo_len != '0) begin
            fifo_rd  <= (fifo_rd == VLAST) ? '0 : fifo_rd + VAW'(1);
            fifo_len <= fifo_len - LW'(1);
          end
        end
        S_FINISH: begin
          clr_reply <= 1'b0;
          if (out_free) begin
            result_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers: the latched transaction, walk pointers and result.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      item_q <= item;
      res    <= '0;
    end
    if (state == S_SEED) begin
      seed_addr <= VAW'(seed_idx);
    end
    case (state)
      S_LOAD_CHK: begin
        if (load_bad) begin
          res.status <= STAT_RANGE;
        end else if (load_full) begin
          res.status <= STAT_FULL;
        end
      end
      S_POP_RD: begin
        if (fifo_len == '0) begin
          res.done_res <= 1'b1;
        end
      end
      S_POP_WAIT: begin
        res.vertex       <= VTX_W'(fifo_rdata) + VTX_W'(1);
        res.vertex_valid <= 1'b1;
      end
      S_HEAD: begin
        link      <= adj_head;
        tail_link <= adj_tail;
        if (adj_head == '0) begin
          res.done_res <= (fifo_len == '0);
        end
      end
      S_DEG_RD: begin
        w_idx     <= tgt_rdata;
        next_link <= nxt_rdata;
      end
      S_DEG_WR: begin
        link <= next_link;
        if (walk_last) begin
          res.done_res <= (fifo_len == '0) && !walk_push;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          result <= res;
        end
      end
      default: begin
      end
    endcase
  end

  // In-degree and queued mark per vertex.
  toe_ram #(.WIDTH(DW + 1), .DEPTH(MAX_VERTICES)) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  // Adjacency list head and tail links per vertex.
  toe_ram #(.WIDTH(2 * EW), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // Target vertex of every stored edge.
  toe_ram #(.WIDTH(VAW), .DEPTH(MAX_EDGES)) u_tgt_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (tgt_waddr),
    .wdata (tgt_wdata),
    .raddr (tgt_raddr),
    .rdata (tgt_rdata)
  );

  // Link to the next edge of the same source. The tail edge's link is never
  // followed, because the walk stops at the tail recorded for the source.
  toe_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_nxt_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (nxt_raddr),
    .rdata (nxt_rdata)
  );

  // Ready queue of vertices whose in-degree reached zero.
  toe_ram #(.WIDTH(VAW), .DEPTH(MAX_VERTICES)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_wr),
    .wdata (fifo_wdata),
    .raddr (fifo_rd),
    .rdata (fifo_rdata)
  );

endmodule

### rtl/toe_checker.sv
// ----------------------------------------------------------------------------
// Topological order engine checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module toe_checker
  import toe_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [VTX_W-1:0] cfg_data,
  input logic             item_valid,
  input logic             item_ready,
  input item_t            item,
  input logic             result_valid,
  input logic             result_ready,
  input result_t          result
);

  // A waiting result transaction keeps its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // An emitted vertex is never vertex zero.
  a_vertex_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.vertex_valid |-> result.vertex != '0)
    else $error("vertex_valid with vertex zero");

  // A load error carries neither a vertex nor a done flag.
  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != STAT_OK |-> !result.vertex_valid && !result.done_res)
    else $error("error status mixed with pull fields");

  // Transactions are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second transaction taken back to back");

endmodule

bind topological_order_engine toe_checker u_toe_checker (.*);
